// ----- rtl/jfss_pkg.sv -----
// Shared types and constants for the JPEG frame size scanner.
`default_nettype none
package jfss_pkg;

    localparam logic [15:0] SCAN_LIMIT_RESET = 16'd4096;

    localparam logic [7:0] MARKER_PREFIX = 8'hFF;
    localparam logic [7:0] SOF0_CODE     = 8'hC0;
    localparam logic [7:0] SOF2_CODE     = 8'hC2;
    localparam logic [7:0] RST0_CODE     = 8'hD0;
    localparam logic [7:0] EOI_CODE      = 8'hD9;
    localparam logic [7:0] STUFF_CODE    = 8'h00;

    localparam logic [2:0] HDR_HEIGHT_HI = 3'd3;
    localparam logic [2:0] HDR_HEIGHT_LO = 3'd4;
    localparam logic [2:0] HDR_WIDTH_HI  = 3'd5;
    localparam logic [2:0] HDR_WIDTH_LO  = 3'd6;

    localparam logic SCAN_LIMIT_ADDR = 1'b0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       image_start;
    } byte_item_t;

    typedef struct packed {
        logic        found;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } result_item_t;

endpackage
`default_nettype wire

// ----- rtl/jfss_scan.sv -----
// Marker parser state and per-byte next-state logic.
`default_nettype none
module jfss_scan (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire jfss_pkg::byte_item_t  item,
    input  wire logic [15:0]           scan_limit,
    output logic                       emit,
    output jfss_pkg::result_item_t     result
);

    typedef enum logic [2:0] {
        PH_SCANNING,
        PH_MARKER,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIPPING,
        PH_HEADER,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] skip_reg, skip_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [2:0]  hdr_reg, hdr_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  width_hi_reg, width_hi_next;

    phase_t      ph;
    logic [15:0] pos;
    logic [15:0] len;
    logic [7:0]  b;
    logic        at_limit;
    logic        room_for_len;
    logic        no_segment;
    logic        is_sof;

    always_comb
    begin
        b            = item.data_byte;
        ph           = item.image_start ? PH_SCANNING : phase_reg;
        pos          = item.image_start ? 16'd0 : pos_reg;
        skip_next    = item.image_start ? 16'd0 : skip_reg;
        len_hi_next  = item.image_start ? 8'd0 : len_hi_reg;
        hdr_next     = item.image_start ? 3'd0 : hdr_reg;
        height_next  = item.image_start ? 16'd0 : height_reg;
        width_hi_next = item.image_start ? 8'd0 : width_hi_reg;
        phase_next   = ph;
        pos_next     = pos;
        len          = {len_hi_next, b};
        at_limit     = pos >= scan_limit;
        room_for_len = ({1'b0, pos} + 17'd2) < {1'b0, scan_limit};
        is_sof       = b >= jfss_pkg::SOF0_CODE && b <= jfss_pkg::SOF2_CODE;
        no_segment   = (b >= jfss_pkg::RST0_CODE && b <= jfss_pkg::EOI_CODE)
                       || b == jfss_pkg::STUFF_CODE || b == jfss_pkg::MARKER_PREFIX;
        emit         = 1'b0;
        result       = '0;

        case (ph)
            PH_SCANNING:
            begin
                if (at_limit)
                begin
                    emit       = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    phase_next = (b == jfss_pkg::MARKER_PREFIX) ? PH_MARKER : PH_SCANNING;
                end
            end
            PH_MARKER:
            begin
                if (is_sof)
                begin
                    phase_next = PH_HEADER;
                    hdr_next   = 3'd0;
                end
                else if (!no_segment && room_for_len)
                begin
                    phase_next = PH_LEN_HI;
                end
                else if (at_limit)
                begin
                    emit       = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    phase_next = (b == jfss_pkg::MARKER_PREFIX) ? PH_MARKER : PH_SCANNING;
                end
            end
            PH_LEN_HI:
            begin
                len_hi_next = b;
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                if (len <= 16'd2)
                begin
                    phase_next = PH_SCANNING;
                end
                else
                begin
                    skip_next  = len - 16'd2;
                    phase_next = PH_SKIPPING;
                end
            end
            PH_SKIPPING:
            begin
                if (at_limit)
                begin
                    emit       = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    if (skip_next != 16'd0)
                    begin
                        skip_next = skip_next - 16'd1;
                    end
                    if (skip_next == 16'd0)
                    begin
                        phase_next = PH_SCANNING;
                    end
                end
            end
            PH_HEADER:
            begin
                case (hdr_next)
                    jfss_pkg::HDR_HEIGHT_HI: height_next[15:8] = b;
                    jfss_pkg::HDR_HEIGHT_LO: height_next[7:0]  = b;
                    jfss_pkg::HDR_WIDTH_HI:  width_hi_next     = b;
                    default: ;
                endcase
                if (hdr_next >= jfss_pkg::HDR_WIDTH_LO)
                begin
                    emit                = 1'b1;
                    result.found        = 1'b1;
                    result.image_width  = {width_hi_next, b};
                    result.image_height = height_next;
                    phase_next          = PH_DONE;
                end
                else
                begin
                    hdr_next = hdr_next + 3'd1;
                end
            end
            default: ;
        endcase

        if (ph != PH_DONE && pos != 16'hFFFF)
        begin
            pos_next = pos + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SCANNING;
            pos_reg      <= '0;
            skip_reg     <= '0;
            len_hi_reg   <= '0;
            hdr_reg      <= '0;
            height_reg   <= '0;
            width_hi_reg <= '0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            skip_reg     <= skip_next;
            len_hi_reg   <= len_hi_next;
            hdr_reg      <= hdr_next;
            height_reg   <= height_next;
            width_hi_reg <= width_hi_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/jpeg_frame_size_scanner.sv -----
// Top level: byte input register, scanner, result register and APB register.
//
// Scans a JPEG byte stream for the first SOF0/SOF1/SOF2 marker and reports
// the frame width and height, or not-found once scan_limit is reached.
// byte channel: one stream byte per transaction, image_start set on the
// first byte of each image. result channel: at most one transaction per
// image (found, image_width, image_height).
// One byte is taken every cycle unless the receiver stalls with a result
// held. A byte passes the input register and then the scanner's state
// update; its result is registered in the result register as the byte
// leaves the input register.
// When the receiver stalls with a result held, the input register keeps its
// byte and byte_ready drops once that register is full; nothing is lost.
// Bytes after a result are consumed without effect until image_start.
// Reset clears the parser state, empties both registers and sets
// scan_limit (APB offset 0x0) to 4096.
`default_nettype none
module jpeg_frame_size_scanner (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    byte_valid,
    output logic                         byte_ready,
    input  wire jfss_pkg::byte_item_t    byte_data,
    output logic                         result_valid,
    input  wire logic                    result_ready,
    output jfss_pkg::result_item_t       result_data,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [2:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic                   limit_wr;
    logic [15:0]            scan_limit_reg;
    logic                   stage_valid_reg;
    jfss_pkg::byte_item_t   stage_item_reg;
    logic                   stage_adv;
    logic                   emit;
    jfss_pkg::result_item_t result;
    logic                   result_valid_reg;
    jfss_pkg::result_item_t result_reg;

    assign pready   = 1'b1;
    assign limit_wr = psel && penable && pwrite && (paddr[2] == jfss_pkg::SCAN_LIMIT_ADDR);
    assign prdata   = (paddr[2] == jfss_pkg::SCAN_LIMIT_ADDR) ? {16'd0, scan_limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_limit_reg <= jfss_pkg::SCAN_LIMIT_RESET;
        end
        else if (limit_wr)
        begin
            scan_limit_reg <= pwdata[15:0];
        end
    end

    assign stage_adv  = stage_valid_reg && (!result_valid_reg || result_ready);
    assign byte_ready = !stage_valid_reg || stage_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (byte_ready)
        begin
            stage_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            stage_item_reg <= byte_data;
        end
    end

    jfss_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (stage_adv),
        .item       (stage_item_reg),
        .scan_limit (scan_limit_reg),
        .emit       (emit),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (stage_adv)
        begin
            result_valid_reg <= emit;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_adv && emit)
        begin
            result_reg <= result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

endmodule
`default_nettype wire

// ----- tb/jfss_size_checker.sv -----
// Checker for the JPEG frame size scanner: tracks byte and APB transactions and compares results.
`timescale 1ns / 100ps
module jfss_size_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    input  logic                   byte_ready,
    input  jfss_pkg::byte_item_t   byte_data,
    input  logic                   result_valid,
    input  logic                   result_ready,
    input  jfss_pkg::result_item_t result_data,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    input  logic                   pready,
    output int                     fail_count,
    output int                     pending_results
);

    typedef enum logic [2:0] {
        PH_SCAN, PH_MARK, PH_LENH, PH_LENL, PH_SKIP, PH_HDR, PH_DONE
    } scan_phase_t;

    localparam logic [2:0] LIMIT_REG_ADDR = {jfss_pkg::SCAN_LIMIT_ADDR, 2'b00};

    scan_phase_t              phase_q;
    logic [15:0]              limit_q;
    logic [15:0]              pos_q;
    logic [16:0]              skip_q;
    logic [7:0]               len_hi_q;
    logic [2:0]               hdr_idx_q;
    logic [15:0]              height_q;
    logic [15:0]              width_q;
    jfss_pkg::result_item_t   expected_sizes[$];
    int                       errors;

    task automatic restart_image();
        phase_q   = PH_SCAN;
        pos_q     = '0;
        skip_q    = '0;
        len_hi_q  = '0;
        hdr_idx_q = '0;
        height_q  = '0;
        width_q   = '0;
    endtask

    task automatic report_not_found();
        jfss_pkg::result_item_t r;
        r = '0;
        expected_sizes.push_back(r);
        phase_q = PH_DONE;
    endtask

    task automatic scan_plain(input logic [7:0] b, input logic [15:0] p);
        if (p >= limit_q)
            report_not_found();
        else
            phase_q = (b == jfss_pkg::MARKER_PREFIX) ? PH_MARK : PH_SCAN;
    endtask

    task automatic predict_sizes(input jfss_pkg::byte_item_t item);
        logic [7:0]             b;
        logic [15:0]            p;
        logic [15:0]            seg_len;
        jfss_pkg::result_item_t r;
        b = item.data_byte;
        if (item.image_start)
            restart_image();
        if (phase_q != PH_DONE)
        begin
            p = pos_q;
            case (phase_q)
                PH_SCAN: scan_plain(b, p);
                PH_MARK:
                begin
                    if (b >= jfss_pkg::SOF0_CODE && b <= jfss_pkg::SOF2_CODE)
                    begin
                        phase_q   = PH_HDR;
                        hdr_idx_q = '0;
                    end
                    else if ((b >= jfss_pkg::RST0_CODE && b <= jfss_pkg::EOI_CODE)
                             || b == jfss_pkg::STUFF_CODE || b == jfss_pkg::MARKER_PREFIX)
                        scan_plain(b, p);
                    else if ({1'b0, p} + 17'd2 < {1'b0, limit_q})
                        phase_q = PH_LENH;
                    else
                        scan_plain(b, p);
                end
                PH_LENH:
                begin
                    len_hi_q = b;
                    phase_q  = PH_LENL;
                end
                PH_LENL:
                begin
                    seg_len = {len_hi_q, b};
                    if (seg_len <= 16'd2)
                        phase_q = PH_SCAN;
                    else
                    begin
                        skip_q  = {1'b0, seg_len} - 17'd2;
                        phase_q = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    if (p >= limit_q)
                        report_not_found();
                    else
                    begin
                        if (skip_q != '0)
                            skip_q = skip_q - 17'd1;
                        if (skip_q == '0)
                            phase_q = PH_SCAN;
                    end
                end
                PH_HDR:
                begin
                    case (hdr_idx_q)
                        jfss_pkg::HDR_HEIGHT_HI: height_q = {b, 8'h00};
                        jfss_pkg::HDR_HEIGHT_LO: height_q = height_q | {8'h00, b};
                        jfss_pkg::HDR_WIDTH_HI:  width_q  = {b, 8'h00};
                        jfss_pkg::HDR_WIDTH_LO:  width_q  = width_q | {8'h00, b};
                        default: ;
                    endcase
                    if (hdr_idx_q >= jfss_pkg::HDR_WIDTH_LO)
                    begin
                        r.found        = 1'b1;
                        r.image_width  = width_q;
                        r.image_height = height_q;
                        expected_sizes.push_back(r);
                        phase_q = PH_DONE;
                    end
                    else
                        hdr_idx_q = hdr_idx_q + 3'd1;
                end
                default: phase_q = PH_DONE;
            endcase
            if (pos_q != 16'hFFFF)
                pos_q = pos_q + 16'd1;
        end
    endtask

    always @(posedge clk)
    begin
        jfss_pkg::result_item_t want;
        if (!rst_n)
        begin
            limit_q = jfss_pkg::SCAN_LIMIT_RESET;
            restart_image();
            expected_sizes.delete();
            errors = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_sizes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result transaction: found=%0b width=%0d height=%0d",
                             $time, result_data.found, result_data.image_width,
                             result_data.image_height);
                end
                else
                begin
                    want = expected_sizes.pop_front();
                    if (result_data.found !== want.found)
                    begin
                        errors++;
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, want.found, result_data.found);
                    end
                    if (result_data.image_width !== want.image_width)
                    begin
                        errors++;
                        $display("%0t: image_width mismatch: expected %0d, actual %0d",
                                 $time, want.image_width, result_data.image_width);
                    end
                    if (result_data.image_height !== want.image_height)
                    begin
                        errors++;
                        $display("%0t: image_height mismatch: expected %0d, actual %0d",
                                 $time, want.image_height, result_data.image_height);
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == LIMIT_REG_ADDR)
                limit_q = pwdata[15:0];
            if (byte_valid && byte_ready)
                predict_sizes(byte_data);
        end
        fail_count      <= errors;
        pending_results <= expected_sizes.size();
    end

endmodule

// ----- tb/jpeg_frame_size_scanner_tb.sv -----
// Testbench top for the JPEG frame size scanner: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module jpeg_frame_size_scanner_tb;

    localparam int          CYCLE_LIMIT    = 3000000;
    localparam int          SETTLE_CYCLES  = 8;
    localparam logic [2:0]  LIMIT_REG_ADDR = {jfss_pkg::SCAN_LIMIT_ADDR, 2'b00};

    logic                     clk;
    logic                     rst_n        = 1'b0;
    logic                     byte_valid   = 1'b0;
    logic                     byte_ready;
    jfss_pkg::byte_item_t     byte_data    = '0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    jfss_pkg::result_item_t   result_data;
    logic                     psel         = 1'b0;
    logic                     penable      = 1'b0;
    logic                     pwrite       = 1'b0;
    logic [2:0]               paddr        = '0;
    logic [31:0]              pwdata       = '0;
    logic [31:0]              prdata;
    logic                     pready;

    int             fail_count;
    int             pending_results;
    int             cycle_count  = 0;
    int             bytes_sent   = 0;
    int             stall_left   = 0;
    bit             idle_enable  = 1'b1;
    logic [7:0]     stream_q[$];

    jpeg_frame_size_scanner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    jfss_size_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (byte_valid),
        .byte_ready      (byte_ready),
        .byte_data       (byte_data),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result_data     (result_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // receiver backpressure in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            result_ready <= 1'b0;
        end
        else if (idle_enable && $urandom_range(0, 11) == 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= $urandom_range(0, 13);
        end
        else
            result_ready <= 1'b1;
    end

    task automatic send_byte(input logic [7:0] d, input logic s, input bit gaps);
        if (gaps && $urandom_range(0, 9) == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= {d, s};
        @(posedge clk);
        while (!byte_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_stream(input bit mangle);
        bit gaps;
        bit s;
        gaps = idle_enable && ($urandom_range(0, 4) != 0);
        foreach (stream_q[i])
        begin
            s = (i == 0) || (mangle && $urandom_range(0, 49) == 0);
            send_byte(stream_q[i], s, gaps);
        end
    endtask

    // hold off until every result is back, then let in-flight bytes settle
    task automatic wait_idle();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_scan_limit(input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_REG_ADDR;
        pwdata  <= {16'h0000, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [15:0] random_dimension();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic build_image();
        int          nseg;
        int          kind;
        int          seg_len;
        int          pay;
        int          keep;
        logic [7:0]  code;
        logic [15:0] h;
        logic [15:0] w;
        logic [7:0]  hdr[$];
        stream_q.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            // raw noise, heavy on 0xFF
            repeat ($urandom_range(1, 40))
                stream_q.push_back(($urandom_range(0, 3) == 0) ? jfss_pkg::MARKER_PREFIX
                                                              : 8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 1) == 1)
        begin
            stream_q.push_back(jfss_pkg::MARKER_PREFIX);
            stream_q.push_back(8'hD8);
        end
        nseg = $urandom_range(0, 4);
        repeat (nseg)
        begin
            kind = $urandom_range(0, 5);
            if (kind == 0)
            begin
                stream_q.push_back(jfss_pkg::MARKER_PREFIX);
                case ($urandom_range(0, 2))
                    0:       stream_q.push_back(8'($urandom_range(jfss_pkg::RST0_CODE,
                                                                  jfss_pkg::EOI_CODE)));
                    1:       stream_q.push_back(jfss_pkg::STUFF_CODE);
                    default: stream_q.push_back(jfss_pkg::MARKER_PREFIX);
                endcase
            end
            else if (kind == 1)
            begin
                repeat ($urandom_range(1, 4)) stream_q.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                do
                    code = 8'($urandom_range(1, 254));
                while ((code >= jfss_pkg::SOF0_CODE && code <= jfss_pkg::SOF2_CODE)
                       || (code >= jfss_pkg::RST0_CODE && code <= jfss_pkg::EOI_CODE));
                stream_q.push_back(jfss_pkg::MARKER_PREFIX);
                stream_q.push_back(code);
                case ($urandom_range(0, 39))
                    0:       seg_len = 0;
                    1:       seg_len = 1;
                    2:       seg_len = 2;
                    3:       seg_len = $urandom_range(3, 400);
                    default: seg_len = $urandom_range(3, 16);
                endcase
                stream_q.push_back(8'(seg_len >> 8));
                stream_q.push_back(8'(seg_len));
                pay = (seg_len > 2) ? seg_len - 2 : 0;
                if ($urandom_range(0, 14) == 0)
                    pay = $urandom_range(0, pay);
                repeat (pay) stream_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 7) != 0)
        begin
            h = random_dimension();
            w = random_dimension();
            hdr = '{jfss_pkg::MARKER_PREFIX, jfss_pkg::SOF0_CODE + 8'($urandom_range(0, 2)),
                    8'h00, 8'h11, 8'h08, h[15:8], h[7:0], w[15:8], w[7:0]};
            repeat ($urandom_range(0, 3)) hdr.push_back(8'($urandom_range(0, 255)));
            keep = ($urandom_range(0, 14) == 0) ? $urandom_range(1, hdr.size()) : hdr.size();
            for (int i = 0; i < keep; i++)
                stream_q.push_back(hdr[i]);
        end
        repeat ($urandom_range(0, 2)) stream_q.push_back(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int          phase_idx;
        logic [15:0] lim;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // repeated 0xFF before SOF0, extreme sizes
        stream_q = '{8'hFF, 8'hFF, 8'hC0, 8'h00, 8'h11, 8'h08, 8'hFF, 8'hFF, 8'h00, 8'h00};
        send_stream(1'b0);
        // short segment length, then SOF2
        stream_q = '{8'hFF, 8'hE0, 8'h00, 8'h02, 8'hFF, 8'hC2, 8'h00, 8'h11, 8'h08,
                     8'h00, 8'h01, 8'hFF, 8'hFE};
        send_stream(1'b0);
        wait_idle();
        // standalone markers up to a tiny limit
        write_scan_limit(16'd4);
        stream_q = '{8'hFF, 8'hD0, 8'hFF, 8'h00, 8'hFF};
        send_stream(1'b0);

        phase_idx = 0;
        while (bytes_sent < 1500)
        begin
            wait_idle();
            case (phase_idx)
                0:       lim = 16'd1;
                1:       lim = 16'hFFFF;
                default:
                    case ($urandom_range(0, 5))
                        0:       lim = 16'($urandom_range(1, 65535));
                        1:       lim = jfss_pkg::SCAN_LIMIT_RESET;
                        2, 3:    lim = 16'($urandom_range(2, 64));
                        default: lim = 16'($urandom_range(65, 600));
                    endcase
            endcase
            write_scan_limit(lim);
            repeat ((phase_idx == 0) ? 3 : $urandom_range(3, 8))
            begin
                build_image();
                send_stream(1'b1);
            end
            phase_idx++;
        end

        wait_idle();
        idle_enable = 1'b0;
        write_scan_limit(16'($urandom_range(20, 300)));
        repeat (10)
        begin
            build_image();
            send_stream(1'b1);
        end

        wait_idle();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
